// File: sv/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg
// Types and constants shared by the integer literal parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ZERO   = 3'd1,
        PH_HEX    = 3'd2,
        PH_BIN    = 3'd3,
        PH_OCT    = 3'd4,
        PH_DEC    = 3'd5,
        PH_NOTINT = 3'd6
    } t_phase;

    typedef logic [1:0] t_status;

    localparam t_status STATUS_DONE    = 2'd0;
    localparam t_status STATUS_STOPPED = 2'd1;
    localparam t_status STATUS_NOT_INT = 2'd2;

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_APOS  = 8'h27;

    localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

endpackage

// File: sv/integer_literal_parser.sv
// ----------------------------------------------------------------------------
// integer_literal_parser
// Parses a C-style integer literal (0x, 0b, leading-0 octal, decimal, with
// apostrophe digit separators) streamed one byte per transfer.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the input is ready. The input is ready
// whenever the result register is empty or is being drained in the same
// cycle, so a stalled result holds off input by exactly that one register.
// A result appears in the cycle after the transfer of the byte marked tlast.
// The cycle time is set by the accumulate path, which for decimal is one
// three-input add of VALUE_WIDTH bits (value times ten plus the digit).

module integer_literal_parser #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [7:0] ch
    input  logic                   i_s_axis_tlast,   // last_byte
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata, // value
    output logic [1:0]             o_m_axis_tuser    // [1:0] status
);

    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    ilp_pkg::t_phase         r_phase, n_phase;
    logic [VALUE_WIDTH-1:0]  r_acc, n_acc;
    logic                    r_sep, n_sep;
    logic                    r_stopped, n_stopped;

    logic                    r_out_valid, n_out_valid;
    logic [VALUE_WIDTH-1:0]  r_out_value, n_out_value;
    ilp_pkg::t_status        r_out_status, n_out_status;

    logic                    in_xfer;
    logic                    dig_ok;
    logic [3:0]              dig;
    ilp_pkg::t_phase         acc_phase;
    logic [VALUE_WIDTH-1:0]  dig_ext;
    logic [VALUE_WIDTH-1:0]  acc_step;
    logic [7:0]              ch;

    assign ch              = i_s_axis_tdata;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // digit value in the current radix
    always_comb begin
        dig_ok = 1'b0;
        dig    = ch[3:0];
        case (r_phase)
            ilp_pkg::PH_HEX: begin
                if (ch >= ilp_pkg::CH_0 && ch <= ilp_pkg::CH_9) begin
                    dig_ok = 1'b1;
                end else if ((ch >= ilp_pkg::CH_A_LO && ch <= ilp_pkg::CH_F_LO) ||
                             (ch >= ilp_pkg::CH_A_UP && ch <= ilp_pkg::CH_F_UP)) begin
                    dig_ok = 1'b1;
                    dig    = ch[3:0] + ilp_pkg::HEX_LETTER_OFS;
                end
            end
            ilp_pkg::PH_BIN: dig_ok = (ch == ilp_pkg::CH_0) || (ch == ilp_pkg::CH_1);
            ilp_pkg::PH_OCT,
            ilp_pkg::PH_ZERO: dig_ok = (ch >= ilp_pkg::CH_0) && (ch <= ilp_pkg::CH_7);
            ilp_pkg::PH_DEC: dig_ok = (ch >= ilp_pkg::CH_0) && (ch <= ilp_pkg::CH_9);
            default: dig_ok = 1'b0;
        endcase
    end

    assign acc_phase = (r_phase == ilp_pkg::PH_ZERO) ? ilp_pkg::PH_OCT : r_phase;
    assign dig_ext   = VALUE_WIDTH'(dig);

    always_comb begin
        case (acc_phase)
            ilp_pkg::PH_HEX: acc_step = (r_acc << 4) | dig_ext;
            ilp_pkg::PH_BIN: acc_step = (r_acc << 1) | dig_ext;
            ilp_pkg::PH_DEC: acc_step = (r_acc << 3) + (r_acc << 1) + dig_ext;
            default:         acc_step = (r_acc << 3) | dig_ext;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_sep        = r_sep;
        n_stopped    = r_stopped;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        if (in_xfer) begin
            if (!r_stopped && r_phase != ilp_pkg::PH_NOTINT) begin
                if (r_phase == ilp_pkg::PH_START) begin
                    if (ch == ilp_pkg::CH_0) begin
                        n_phase = ilp_pkg::PH_ZERO;
                    end else if (ch >= ilp_pkg::CH_1 && ch <= ilp_pkg::CH_9) begin
                        n_phase = ilp_pkg::PH_DEC;
                        n_acc   = VALUE_WIDTH'(ch[3:0]);
                    end else begin
                        n_phase = ilp_pkg::PH_NOTINT;
                    end
                end else if (r_sep) begin
                    n_sep = 1'b0;
                    if (dig_ok) begin
                        n_phase = acc_phase;
                        n_acc   = acc_step;
                    end else begin
                        n_stopped = 1'b1;
                    end
                end else if (dig_ok) begin
                    n_phase = acc_phase;
                    n_acc   = acc_step;
                end else if (r_phase == ilp_pkg::PH_ZERO &&
                             (ch == ilp_pkg::CH_X_LO || ch == ilp_pkg::CH_X_UP)) begin
                    n_phase = ilp_pkg::PH_HEX;
                end else if (r_phase == ilp_pkg::PH_ZERO &&
                             (ch == ilp_pkg::CH_B_LO || ch == ilp_pkg::CH_B_UP)) begin
                    n_phase = ilp_pkg::PH_BIN;
                end else if (ch == ilp_pkg::CH_APOS) begin
                    n_phase = acc_phase;
                    n_sep   = 1'b1;
                end else begin
                    n_stopped = 1'b1;
                end
            end

            if (i_s_axis_tlast) begin
                n_out_valid = 1'b1;
                if (n_phase == ilp_pkg::PH_NOTINT) begin
                    n_out_value  = '0;
                    n_out_status = ilp_pkg::STATUS_NOT_INT;
                end else begin
                    n_out_value  = n_acc;
                    n_out_status = (n_stopped || n_sep) ? ilp_pkg::STATUS_STOPPED
                                                        : ilp_pkg::STATUS_DONE;
                end
                n_phase   = ilp_pkg::PH_START;
                n_acc     = '0;
                n_sep     = 1'b0;
                n_stopped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ilp_pkg::PH_START;
            r_acc       <= '0;
            r_sep       <= 1'b0;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_acc       <= n_acc;
            r_sep       <= n_sep;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out_value);
    assign o_m_axis_tuser  = r_out_status;

    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_s_axis_tlast) |=>
            (r_phase == ilp_pkg::PH_START && !r_sep && !r_stopped && r_out_valid))
        else $error("state not cleared after last byte");

    a_start_acc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ilp_pkg::PH_START) |-> (r_acc == '0))
        else $error("accumulator nonzero at start of literal");

    a_sep_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sep |-> (r_phase == ilp_pkg::PH_HEX || r_phase == ilp_pkg::PH_BIN ||
                   r_phase == ilp_pkg::PH_OCT || r_phase == ilp_pkg::PH_DEC))
        else $error("separator pending outside a radix phase");

    a_notint_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ilp_pkg::STATUS_NOT_INT) |-> (r_out_value == '0))
        else $error("not-integer result with nonzero value");

    a_no_status3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status != 2'd3))
        else $error("undefined status code");

endmodule
